FILE: rtl/dpc_pkg.sv
// dpc_pkg: types, constants and command codes of the difference pair counter
// depends on nothing; used by every rtl file of the block but dpc_ram
package dpc_pkg;

	localparam int VALUE_W = 30;
	localparam int TOTAL_W = 24;
	localparam int COUNT_W = 13;
	localparam int EPOCH_W = 8;
	localparam int DEFAULT_SLOTS = 4096;

	localparam logic [VALUE_W-1:0] DIFF_RESET = VALUE_W'(1);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} in_beat_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] pair_count;
		logic               overflow;
	} out_beat_t;

	typedef struct packed {
		logic               vld;
		logic [EPOCH_W-1:0] epoch;
		logic [COUNT_W-1:0] count;
		logic [VALUE_W-1:0] key;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_TAKE,
		CMD_START,
		CMD_PROBE,
		CMD_CLEAR,
		CMD_EMIT
	} cmd_op_t;

	typedef enum logic [1:0] {
		KIND_LO,
		KIND_HI,
		KIND_INS
	} probe_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_PROBE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		cmd_op_t     op;
		probe_kind_t kind;
	} dpc_cmd_t;

	typedef struct packed {
		logic key_ok;
		logic done;
		logic clr_last;
		logic last;
		logic out_busy;
		logic epoch_wrap;
	} dpc_stat_t;

endpackage

FILE: rtl/dpc_ram.sv
// dpc_ram: generic one-write one-read memory with registered read data
// depends on nothing
module dpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/dpc_ctrl.sv
// dpc_ctrl: sequencer for clear sweep, the two lookups, the insert and the result
// depends on dpc_pkg
module dpc_ctrl
	import dpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dpc_stat_t stat,
	output dpc_cmd_t  cmd
);

	state_t      state_q, state_d;
	probe_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kind_q  <= KIND_LO;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		in_ready = 1'b0;
		cmd.op   = CMD_NONE;
		cmd.kind = kind_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = CMD_CLEAR;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = CMD_TAKE;
					kind_d  = KIND_LO;
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (stat.key_ok) begin
					cmd.op  = CMD_START;
					state_d = ST_PROBE;
				end else if (kind_q == KIND_LO) begin
					kind_d = KIND_HI;
				end else begin
					kind_d = KIND_INS;
				end
			end
			ST_PROBE: begin
				cmd.op = CMD_PROBE;
				if (stat.done) begin
					unique case (kind_q)
						KIND_LO: begin
							kind_d  = KIND_HI;
							state_d = ST_START;
						end
						KIND_HI: begin
							kind_d  = KIND_INS;
							state_d = ST_START;
						end
						default: begin
							state_d = stat.last ? ST_EMIT : ST_IDLE;
						end
					endcase
				end
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					cmd.op  = CMD_EMIT;
					state_d = stat.epoch_wrap ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

FILE: rtl/dpc_datapath.sv
// dpc_datapath: slot table, probe position, running total and result register
// depends on dpc_pkg and dpc_ram
module dpc_datapath
	import dpc_pkg::*;
#(
	parameter int TABLE_SLOTS = DEFAULT_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  in_beat_t           in_data,
	input  logic               cfg_we,
	input  logic [VALUE_W-1:0] cfg_data,
	input  dpc_cmd_t           cmd,
	output dpc_stat_t          stat,
	output logic               out_valid,
	input  logic               out_ready,
	output out_beat_t          out_data
);

	localparam int IW = $clog2(TABLE_SLOTS);

	logic [VALUE_W-1:0] diff_q;
	logic [VALUE_W-1:0] x_q;
	logic               last_q;
	logic [IW-1:0]      pos_q, n_q, clr_q;
	logic [TOTAL_W-1:0] total_q;
	logic               ovf_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               out_valid_q;
	out_beat_t          out_q;

	logic [VALUE_W:0]   lo_w, hi_w;
	logic               diff_zero;
	logic [VALUE_W-1:0] key;
	logic               key_ok;
	logic [IW:0]        home_w;
	logic [IW-1:0]      home, pos_next;
	slot_t              rd, wd;
	logic               we;
	logic [IW-1:0]      waddr, raddr;
	logic               live, hit, empty, full, done;
	logic [COUNT_W-1:0] cnt;
	logic [COUNT_W:0]   amt;
	logic [TOTAL_W:0]   sum_w;
	logic               probing;

	dpc_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wd),
		.raddr(raddr),
		.rdata(rd)
	);

	// key of the current search
	always_comb begin
		lo_w      = {1'b0, x_q} - {1'b0, diff_q};
		hi_w      = {1'b0, x_q} + {1'b0, diff_q};
		diff_zero = (diff_q == '0);
		case (cmd.kind)
			KIND_LO: begin
				key    = diff_zero ? x_q : lo_w[VALUE_W-1:0];
				key_ok = diff_zero | ~lo_w[VALUE_W];
			end
			KIND_HI: begin
				key    = hi_w[VALUE_W-1:0];
				key_ok = ~diff_zero & ~hi_w[VALUE_W];
			end
			default: begin
				key    = x_q;
				key_ok = 1'b1;
			end
		endcase
		// home slot
		home_w = (IW+1)'(key[IW-1:0]);
		if (home_w >= (IW+1)'(TABLE_SLOTS)) begin
			home_w = home_w - (IW+1)'(TABLE_SLOTS);
		end
		home     = home_w[IW-1:0];
		pos_next = (pos_q == IW'(TABLE_SLOTS - 1)) ? '0 : pos_q + 1'b1;
	end

	always_comb begin
		probing = (cmd.op == CMD_PROBE);
		live    = rd.vld & (rd.epoch == epoch_q);
		hit     = live & (rd.key == key);
		empty   = ~live;
		full    = live & ~hit & (n_q == IW'(TABLE_SLOTS - 1));
		done    = probing & (hit | empty | full);
		cnt     = hit ? rd.count : '0;
		amt     = diff_zero ? {cnt, 1'b1} : {1'b0, cnt};
		sum_w   = {1'b0, total_q} + (TOTAL_W+1)'(amt);

		raddr = (cmd.op == CMD_START) ? home : pos_next;

		we       = 1'b0;
		waddr    = pos_q;
		wd.vld   = 1'b1;
		wd.epoch = epoch_q;
		wd.key   = key;
		wd.count = COUNT_W'(1);
		if (cmd.op == CMD_CLEAR) begin
			we     = 1'b1;
			waddr  = clr_q;
			wd.vld = 1'b0;
		end else if (done && cmd.kind == KIND_INS && !full) begin
			we = 1'b1;
			if (hit) begin
				wd.count = (rd.count == COUNT_MAX) ? rd.count : rd.count + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q      <= DIFF_RESET;
			clr_q       <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			epoch_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				diff_q <= cfg_data;
			end
			if (cmd.op == CMD_CLEAR) begin
				clr_q <= (clr_q == IW'(TABLE_SLOTS - 1)) ? '0 : clr_q + 1'b1;
			end
			if (done && cmd.kind != KIND_INS) begin
				total_q <= (sum_w > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
					: sum_w[TOTAL_W-1:0];
			end
			if (done && cmd.kind == KIND_INS && full) begin
				ovf_q <= 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.op == CMD_EMIT) begin
				out_valid_q <= 1'b1;
				total_q     <= '0;
				ovf_q       <= 1'b0;
				epoch_q     <= epoch_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_TAKE) begin
			x_q    <= in_data.value;
			last_q <= in_data.last;
		end
		if (cmd.op == CMD_START) begin
			pos_q <= home;
			n_q   <= '0;
		end else if (probing) begin
			pos_q <= pos_next;
			n_q   <= n_q + 1'b1;
		end
		if (cmd.op == CMD_EMIT) begin
			out_q.pair_count <= total_q;
			out_q.overflow   <= ovf_q;
		end
	end

	assign stat.key_ok     = key_ok;
	assign stat.done       = done;
	assign stat.clr_last   = (clr_q == IW'(TABLE_SLOTS - 1));
	assign stat.last       = last_q;
	assign stat.out_busy   = out_valid_q & ~out_ready;
	assign stat.epoch_wrap = (epoch_q == '1);
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

FILE: rtl/difference_pair_counter.sv
// difference_pair_counter: top level, counts ordered pairs with a set difference
// depends on dpc_pkg, dpc_ctrl, dpc_datapath and dpc_ram
//
// in_valid/in_ready/in_data carry one sequence element per beat; the beat
// marked last closes the sequence. out_valid/out_ready/out_data carry one
// beat per sequence: the saturating pair count and the table overflow flag.
// cfg_we/cfg_data write the difference; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Each element runs the two lookups and the insert in the slot table in
// turn, each a probe of one table read per cycle through its single read
// port, and in_ready stays low until the element is done. A lookup whose key
// falls out of range is skipped. After the last beat the result is emitted.
// After reset, and after every 256th sequence, a sweep marks every slot
// empty; in_ready stays low meanwhile. Other sequences start on a fresh
// table at once by bumping an epoch tag.
// The result sits in an output register: further elements are taken while
// it waits, and only the next last beat stalls until the receiver takes it.
module difference_pair_counter
	import dpc_pkg::*;
#(
	parameter int TABLE_SLOTS = DEFAULT_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_beat_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_beat_t          out_data,
	input  logic               cfg_we,
	input  logic [VALUE_W-1:0] cfg_data
);

	dpc_cmd_t  cmd;
	dpc_stat_t stat;

	dpc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dpc_datapath #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

FILE: sim/difference_pair_counter_tb.sv
// difference_pair_counter_tb: self-checking bench for the difference pair counter
// needs dpc_pkg and the rtl of difference_pair_counter; keeps its own pair
// counting table and compares every emitted beat against it
`timescale 1ns / 100ps

module difference_pair_counter_tb;
	import dpc_pkg::*;

	localparam int SLOTS = 4096;
	localparam longint CYCLE_LIMIT = 3000000;

	class pair_scoreboard;
		logic [VALUE_W-1:0] keys [SLOTS];
		logic [COUNT_W-1:0] counts [SLOTS];
		bit                 used [SLOTS];
		logic [VALUE_W-1:0] diff;
		int unsigned        total;
		bit                 ovf;
		out_beat_t          pending [$];
		int                 errors;

		function new();
			diff = DIFF_RESET;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (used[i]) used[i] = 0;
			total = 0;
			ovf = 0;
		endfunction

		// slot holding key, or first free slot (hit = 0), or -1 when full
		function int find_slot(logic [VALUE_W-1:0] key, output bit hit);
			int pos;
			pos = key % SLOTS;
			hit = 0;
			for (int n = 0; n < SLOTS; n++) begin
				if (!used[pos]) return pos;
				if (keys[pos] == key) begin
					hit = 1;
					return pos;
				end
				pos = (pos + 1) % SLOTS;
			end
			return -1;
		endfunction

		function int unsigned count_of(longint key);
			bit hit;
			int s;
			if (key < 0 || key > 64'h3FFF_FFFF) return 0;
			s = find_slot(key[VALUE_W-1:0], hit);
			return hit ? counts[s] : 0;
		endfunction

		function void add(longint amt);
			longint t;
			t = total + amt;
			total = (t > TOTAL_MAX) ? TOTAL_MAX : 32'(t);
		endfunction

		function void note_beat(in_beat_t b);
			bit hit;
			int s;
			out_beat_t r;
			if (diff == 0) begin
				add(2 * longint'(count_of(b.value)) + 1);
			end else begin
				add(count_of(longint'(b.value) - diff));
				add(count_of(longint'(b.value) + diff));
			end
			s = find_slot(b.value, hit);
			if (s < 0) ovf = 1;
			else if (hit) begin
				if (counts[s] != COUNT_MAX) counts[s]++;
			end else begin
				used[s] = 1;
				keys[s] = b.value;
				counts[s] = 1;
			end
			if (b.last) begin
				r.pair_count = TOTAL_W'(total);
				r.overflow = ovf;
				pending.push_back(r);
				wipe();
			end
		endfunction

		function void check_beat(out_beat_t got);
			out_beat_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.pair_count !== want.pair_count) begin
				$display("%0t: pair_count expected %0d actual %0d", $time,
					want.pair_count, got.pair_count);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$display("%0t: overflow expected %0d actual %0d", $time,
					want.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	in_beat_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 0;
	out_beat_t          out_data;
	logic               cfg_we = 0;
	logic [VALUE_W-1:0] cfg_data = '0;

	pair_scoreboard sb = new();
	longint cycles = 0;
	bit sending = 1;
	int hold = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	difference_pair_counter #(.TABLE_SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 4) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
		return $urandom_range(1, 4);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver side with random stalls, mostly short and a few long
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_beat(out_data);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold <= hold - 1;
			end else if ($urandom_range(0, 39) == 0) begin
				out_ready <= 1'b0;
				hold <= $urandom_range(20, 80);
			end else begin
				out_ready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
			end
		end
	end

	task automatic send_beat(logic [VALUE_W-1:0] v, logic lst);
		int g;
		g = sending ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{value: v, last: lst};
		do @(posedge clk); while (!in_ready);
		sb.note_beat(in_data);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 0;
		while (sb.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic set_diff(logic [VALUE_W-1:0] d);
		drain();
		cfg_we <= 1;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
		sb.diff = d;
	endtask

	// mostly clustered values so pairs actually form
	task automatic random_seq(int n, logic [VALUE_W-1:0] base, int spread);
		logic [VALUE_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: v = VALUE_W'($urandom());
				1: v = VALUE_W'(base + sb.diff * $urandom_range(0, 3));
				default: v = VALUE_W'(base + $urandom_range(0, spread));
			endcase
			send_beat(v, i == n - 1);
		end
	endtask

	initial begin
		int items;
		logic [VALUE_W-1:0] base;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: reset difference, extremes and out-of-range neighbours, then the largest, zero and table-size differences
		send_beat(30'd5, 0);
		send_beat(30'd6, 0);
		send_beat(30'd4, 0);
		send_beat(30'd0, 0);
		send_beat(30'h3FFF_FFFF, 0);
		send_beat(30'h3FFF_FFFE, 1);
		send_beat(30'd7, 1);
		set_diff(30'h3FFF_FFFF);
		send_beat(30'h3FFF_FFFF, 0);
		send_beat(30'd0, 0);
		send_beat(30'd0, 1);
		set_diff(30'd0);
		send_beat(30'd9, 0);
		send_beat(30'd9, 0);
		send_beat(VALUE_W'(9 + SLOTS), 0);
		send_beat(30'd9, 1);
		set_diff(30'd4096);
		send_beat(30'd3, 0);
		send_beat(VALUE_W'(3 + SLOTS), 0);
		send_beat(VALUE_W'(3 + 2 * SLOTS), 0);
		send_beat(30'd4095, 0);
		send_beat(VALUE_W'(4095 + SLOTS), 1);

		// sender holds off until everything is out
		sending = 0;
		drain();
		sending = 1;

		items = 0;
		while (items < 430) begin
			if ($urandom_range(0, 3) == 0)
				set_diff($urandom_range(0, 5) == 0 ? VALUE_W'($urandom()) :
					VALUE_W'($urandom_range(0, 8)));
			base = ($urandom_range(0, 3) == 0) ? 30'h3FFF_FFF0 :
				VALUE_W'($urandom_range(0, 50));
			begin
				int n;
				n = $urandom_range(1, 20);
				random_seq(n, base, 12);
				items += n;
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

FILE: files.f
rtl/dpc_pkg.sv
rtl/dpc_ram.sv
rtl/dpc_ctrl.sv
rtl/dpc_datapath.sv
rtl/difference_pair_counter.sv
sim/difference_pair_counter_tb.sv
